// ===== rtl/core/julia_escape_time_iterator_unit_assert.svh =====
// assertion macros for the escape-time iterator
// each use expects clk and rst_n in scope
`ifndef JULIA_ESCAPE_TIME_ITERATOR_UNIT_ASSERT_SVH
`define JULIA_ESCAPE_TIME_ITERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define JETI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JETI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jeti_pkg.sv =====
package jeti_pkg;

  localparam int FRACTION_BITS = 28;
  localparam int COUNT_BITS    = 16;

  localparam int Z_W     = 32;
  localparam int DZ_W    = 40;
  localparam int MAG_W   = 40;
  localparam int DMAG_W  = 48;
  localparam int MAG_FRAC = 24;
  localparam int DZ_FRAC  = 24;
  localparam int MAG_SHIFT = 2 * FRACTION_BITS - MAG_FRAC;

  // shared multiplier: a full operand times half of b per pass
  localparam int MUL_AW = 40;
  localparam int MUL_CW = MUL_AW / 2;
  localparam int MUL_PW = MUL_AW + MUL_CW;
  localparam int MUL_RW = 2 * MUL_AW;

  localparam int MAG_SUM_W  = 2 * Z_W + 1;
  localparam int DMAG_SUM_W = MUL_RW - DZ_FRAC + 1;

  localparam logic [MAG_W-1:0] BAIL_STD = MAG_W'(4) << MAG_FRAC;
  localparam logic [MAG_W-1:0] BAIL_LOG = MAG_W'(16) << MAG_FRAC;
  localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(256);

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_LINEAR,
    MODE_LOG,
    MODE_DIST
  } mode_t;

  typedef enum logic [1:0] {
    REG_SEED_REAL,
    REG_SEED_IMAG,
    REG_ITER_LIMIT,
    REG_SMOOTH_MODE
  } reg_idx_t;

  typedef struct packed {
    logic [Z_W-1:0]        seed_real;
    logic [Z_W-1:0]        seed_imag;
    logic [COUNT_BITS-1:0] limit;
    mode_t                 mode;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_AW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_RW-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  in_set;
    logic [MAG_W-1:0]      fmag;
    logic [MAG_W-1:0]      pmag;
    logic [DMAG_W-1:0]     dmag;
  } result_t;

  function automatic logic [Z_W-1:0] abs_z(input logic [Z_W-1:0] v);
    return v[Z_W-1] ? Z_W'(-v) : v;
  endfunction

  function automatic logic [DZ_W-1:0] abs_dz(input logic [DZ_W-1:0] v);
    return v[DZ_W-1] ? DZ_W'(-v) : v;
  endfunction

  function automatic logic [MAG_W-1:0] sat_mag(input logic [MAG_SUM_W-1:0] v);
    return (|v[MAG_SUM_W-1:MAG_W]) ? {MAG_W{1'b1}} : v[MAG_W-1:0];
  endfunction

  function automatic logic [DMAG_W-1:0] sat_dmag(input logic [DMAG_SUM_W-1:0] v);
    return (|v[DMAG_SUM_W-1:DMAG_W]) ? {DMAG_W{1'b1}} : v[DMAG_W-1:0];
  endfunction

endpackage

// ===== rtl/core/jeti_mul.sv =====
module jeti_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  jeti_pkg::mul_req_t req,
  output jeti_pkg::mul_rsp_t rsp
);
  import jeti_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM
  } phase_t;

  phase_t            phase_r;
  logic              done_r;
  logic [MUL_PW-1:0] part_r;
  logic [MUL_RW-1:0] acc_r;
  logic [MUL_CW-1:0] chunk;
  logic [MUL_PW-1:0] part_nxt;

  // operands held stable by the sequencer for the whole product
  assign chunk    = (phase_r == PH_HI) ? req.b[MUL_AW-1:MUL_CW] : req.b[MUL_CW-1:0];
  assign part_nxt = MUL_PW'(req.a) * MUL_PW'(chunk);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          if (req.start) phase_r <= PH_LO;
        end
        PH_LO: begin
          part_r  <= part_nxt;
          phase_r <= PH_HI;
        end
        PH_HI: begin
          part_r  <= part_nxt;
          acc_r   <= MUL_RW'(part_r);
          phase_r <= PH_SUM;
        end
        PH_SUM: begin
          acc_r   <= acc_r + (MUL_RW'(part_r) << MUL_CW);
          done_r  <= 1'b1;
          phase_r <= PH_IDLE;
        end
        default: phase_r <= PH_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== rtl/core/jeti_seq.sv =====
module jeti_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jeti_pkg::cfg_t             cfg,
  input  logic                       start,
  input  logic [jeti_pkg::Z_W-1:0]   start_real,
  input  logic [jeti_pkg::Z_W-1:0]   start_imag,
  output logic                       idle,
  output jeti_pkg::mul_req_t         mul_req,
  input  jeti_pkg::mul_rsp_t         mul_rsp,
  output logic                       res_valid,
  input  logic                       res_ready,
  output jeti_pkg::result_t          res
);
  import jeti_pkg::*;

  // working widths for the z update and the derivative terms
  localparam int NXW = (66 - FRACTION_BITS > Z_W + 2) ? 66 - FRACTION_BITS : Z_W + 2;
  localparam int TW  = 72 - FRACTION_BITS;
  localparam int DW  = (TW + 2 > DZ_W + 1) ? TW + 2 : DZ_W + 1;
  localparam int DPW = MUL_RW - DZ_FRAC;
  localparam logic [DZ_W-1:0] DZ_ONE = DZ_W'(1) << DZ_FRAC;
  localparam logic [DZ_W-1:0] DZ_MAX = {1'b0, {(DZ_W-1){1'b1}}};
  localparam logic [DZ_W-1:0] DZ_MIN = {1'b1, {(DZ_W-1){1'b0}}};
  localparam logic [Z_W-1:0]  Z_MAX  = {1'b0, {(Z_W-1){1'b1}}};
  localparam logic [Z_W-1:0]  Z_MIN  = {1'b1, {(Z_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_CHECK,
    S_XY,
    S_ZUPD,
    S_ZXDX,
    S_ZYDY,
    S_ZYDX,
    S_ZXDY,
    S_DUPD,
    S_DXX,
    S_DYY,
    S_DONE
  } state_t;

  state_t                state_r;
  logic                  issued_r;
  logic [Z_W-1:0]        zx_r, zy_r;
  logic [DZ_W-1:0]       dx_r, dy_r;
  logic [2*Z_W-1:0]      sxx_r, syy_r, sxy_r;
  logic [MAG_W-1:0]      mag_r, prev_r;
  logic                  inside_r;
  logic [COUNT_BITS-1:0] count_r;
  logic signed [TW-1:0]  t0_r, t1_r, t2_r, t3_r;
  logic [DPW-1:0]        dxx_r;
  logic [DMAG_W-1:0]     dmag_r;

  logic [Z_W-1:0]        ax, ay;
  logic [DZ_W-1:0]       adx, ady;
  logic                  use_mul, term_neg;
  logic [MUL_AW-1:0]     op_a, op_b;
  logic                  dist_on;
  logic [MAG_W-1:0]      bail;
  logic [MAG_W-1:0]      mag_nxt;
  logic                  go_on;
  logic signed [NXW-1:0] sx_s, sy_s, pxy_s, cre_s, cim_s, nx_w, ny_w;
  logic [NXW-Z_W:0]      nx_hi, ny_hi;
  logic [Z_W-1:0]        nx_sat, ny_sat;
  logic [TW-1:0]         tmag;
  logic signed [TW-1:0]  term;
  logic signed [DW-1:0]  ndx, ndy;
  logic [DW-DZ_W:0]      ndx_hi, ndy_hi;
  logic [DZ_W-1:0]       dx_sat, dy_sat;
  logic [DPW-1:0]        dprod;

  assign ax  = abs_z(zx_r);
  assign ay  = abs_z(zy_r);
  assign adx = abs_dz(dx_r);
  assign ady = abs_dz(dy_r);

  assign dist_on = (cfg.mode == MODE_DIST);
  assign bail    = (cfg.mode == MODE_LOG) ? BAIL_LOG : BAIL_STD;

  // operand routing into the shared multiplier
  always_comb begin
    use_mul  = 1'b0;
    term_neg = 1'b0;
    op_a     = '0;
    op_b     = '0;
    unique case (state_r)
      S_SQX: begin
        use_mul = 1'b1; op_a = MUL_AW'(ax); op_b = MUL_AW'(ax);
      end
      S_SQY: begin
        use_mul = 1'b1; op_a = MUL_AW'(ay); op_b = MUL_AW'(ay);
      end
      S_XY: begin
        use_mul = 1'b1; op_a = MUL_AW'(ax); op_b = MUL_AW'(ay);
      end
      S_ZXDX: begin
        use_mul = 1'b1; op_a = MUL_AW'(adx); op_b = MUL_AW'(ax);
        term_neg = zx_r[Z_W-1] ^ dx_r[DZ_W-1];
      end
      S_ZYDY: begin
        use_mul = 1'b1; op_a = MUL_AW'(ady); op_b = MUL_AW'(ay);
        term_neg = zy_r[Z_W-1] ^ dy_r[DZ_W-1];
      end
      S_ZYDX: begin
        use_mul = 1'b1; op_a = MUL_AW'(adx); op_b = MUL_AW'(ay);
        term_neg = zy_r[Z_W-1] ^ dx_r[DZ_W-1];
      end
      S_ZXDY: begin
        use_mul = 1'b1; op_a = MUL_AW'(ady); op_b = MUL_AW'(ax);
        term_neg = zx_r[Z_W-1] ^ dy_r[DZ_W-1];
      end
      S_DXX: begin
        use_mul = 1'b1; op_a = MUL_AW'(adx); op_b = MUL_AW'(adx);
      end
      S_DYY: begin
        use_mul = 1'b1; op_a = MUL_AW'(ady); op_b = MUL_AW'(ady);
      end
      default: ;
    endcase
  end

  assign mul_req.start = use_mul && !issued_r;
  assign mul_req.a     = op_a;
  assign mul_req.b     = op_b;

  // |z|^2 and the escape test
  assign mag_nxt = sat_mag(MAG_SUM_W'(sxx_r >> MAG_SHIFT) + MAG_SUM_W'(syy_r >> MAG_SHIFT));
  assign go_on   = (mag_nxt < bail) && (count_r < cfg.limit);

  // z update
  assign sx_s  = signed'(NXW'(sxx_r >> FRACTION_BITS));
  assign sy_s  = signed'(NXW'(syy_r >> FRACTION_BITS));
  assign pxy_s = signed'(NXW'({sxy_r, 1'b0} >> FRACTION_BITS));
  assign cre_s = signed'({{(NXW-Z_W){cfg.seed_real[Z_W-1]}}, cfg.seed_real});
  assign cim_s = signed'({{(NXW-Z_W){cfg.seed_imag[Z_W-1]}}, cfg.seed_imag});
  assign nx_w  = sx_s - sy_s + cre_s;
  assign ny_w  = (zx_r[Z_W-1] ^ zy_r[Z_W-1]) ? cim_s - pxy_s : cim_s + pxy_s;
  assign nx_hi = nx_w[NXW-1:Z_W-1];
  assign ny_hi = ny_w[NXW-1:Z_W-1];

  always_comb begin
    if (nx_hi == '0 || nx_hi == '1) nx_sat = nx_w[Z_W-1:0];
    else if (nx_w[NXW-1])           nx_sat = Z_MIN;
    else                            nx_sat = Z_MAX;
    if (ny_hi == '0 || ny_hi == '1) ny_sat = ny_w[Z_W-1:0];
    else if (ny_w[NXW-1])           ny_sat = Z_MIN;
    else                            ny_sat = Z_MAX;
  end

  // derivative terms, truncated toward zero
  assign tmag = TW'(mul_rsp.prod >> FRACTION_BITS);
  assign term = term_neg ? -signed'(tmag) : signed'(tmag);

  assign ndx    = (DW'(t0_r) - DW'(t1_r)) <<< 1;
  assign ndy    = (DW'(t2_r) + DW'(t3_r)) <<< 1;
  assign ndx_hi = ndx[DW-1:DZ_W-1];
  assign ndy_hi = ndy[DW-1:DZ_W-1];

  always_comb begin
    if (ndx_hi == '0 || ndx_hi == '1) dx_sat = ndx[DZ_W-1:0];
    else if (ndx[DW-1])               dx_sat = DZ_MIN;
    else                              dx_sat = DZ_MAX;
    if (ndy_hi == '0 || ndy_hi == '1) dy_sat = ndy[DZ_W-1:0];
    else if (ndy[DW-1])               dy_sat = DZ_MIN;
    else                              dy_sat = DZ_MAX;
  end

  assign dprod = mul_rsp.prod[MUL_RW-1:DZ_FRAC];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            zx_r    <= start_real;
            zy_r    <= start_imag;
            dx_r    <= DZ_ONE;
            dy_r    <= '0;
            count_r <= '0;
            prev_r  <= '0;
            dmag_r  <= '0;
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          if (mul_rsp.done) begin
            sxx_r   <= mul_rsp.prod[2*Z_W-1:0];
            state_r <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_rsp.done) begin
            syy_r   <= mul_rsp.prod[2*Z_W-1:0];
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          mag_r    <= mag_nxt;
          inside_r <= (mag_nxt < bail);
          if (go_on)        state_r <= S_XY;
          else if (dist_on) state_r <= S_DXX;
          else              state_r <= S_DONE;
        end
        S_XY: begin
          if (mul_rsp.done) begin
            sxy_r   <= mul_rsp.prod[2*Z_W-1:0];
            state_r <= S_ZUPD;
          end
        end
        S_ZUPD: begin
          prev_r  <= mag_r;
          zx_r    <= nx_sat;
          zy_r    <= ny_sat;
          count_r <= count_r + 1'b1;
          state_r <= dist_on ? S_ZXDX : S_SQX;
        end
        S_ZXDX: begin
          if (mul_rsp.done) begin
            t0_r    <= term;
            state_r <= S_ZYDY;
          end
        end
        S_ZYDY: begin
          if (mul_rsp.done) begin
            t1_r    <= term;
            state_r <= S_ZYDX;
          end
        end
        S_ZYDX: begin
          if (mul_rsp.done) begin
            t2_r    <= term;
            state_r <= S_ZXDY;
          end
        end
        S_ZXDY: begin
          if (mul_rsp.done) begin
            t3_r    <= term;
            state_r <= S_DUPD;
          end
        end
        S_DUPD: begin
          dx_r    <= dx_sat;
          dy_r    <= dy_sat;
          state_r <= S_SQX;
        end
        S_DXX: begin
          if (mul_rsp.done) begin
            dxx_r   <= dprod;
            state_r <= S_DYY;
          end
        end
        S_DYY: begin
          if (mul_rsp.done) begin
            dmag_r  <= sat_dmag(DMAG_SUM_W'(dxx_r) + DMAG_SUM_W'(dprod));
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (mul_req.start)     issued_r <= 1'b1;
      else if (mul_rsp.done) issued_r <= 1'b0;
    end
  end

  assign idle       = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.count  = count_r;
  assign res.in_set = inside_r;
  assign res.fmag   = mag_r;
  assign res.pmag   = prev_r;
  assign res.dmag   = dmag_r;

endmodule

// ===== rtl/core/julia_escape_time_iterator_unit.sv =====
// julia set escape-time iterator. each input beat carries one pixel's start
// point z0 (signed q4.28); the block iterates z = z^2 + c with c taken from the
// seed registers until |z|^2 reaches the bailout (16.0 in logarithmic mode,
// 4.0 otherwise) or the iteration limit is hit, and returns one output beat
// with the count, the inside flag, the final and previous |z|^2 (q16.24) and,
// in distance mode, |dz|^2 (q24.24) of the derivative dz = 2*z*dz started at
// 1.0; all results saturate. every product goes through one shared 40x20
// multiplier that needs two passes, over the low and then the high half of b,
// followed by a summing step; the input is ready only while no pixel is in
// flight. a finished result sits in the output register, so the next pixel
// can be taken while the previous result waits. configuration is written
// through cfg_we/cfg_index/cfg_wdata; the user must write it only while the
// block is idle, which the block itself does not enforce.
`include "julia_escape_time_iterator_unit_assert.svh"

module julia_escape_time_iterator_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // pixel input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [jeti_pkg::Z_W-1:0]      in_start_real,
  input  logic signed [jeti_pkg::Z_W-1:0]      in_start_imag,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [jeti_pkg::COUNT_BITS-1:0]      out_iteration_count,
  output logic                                 out_inside_set,
  output logic [jeti_pkg::MAG_W-1:0]           out_final_magnitude_sq,
  output logic [jeti_pkg::MAG_W-1:0]           out_previous_magnitude_sq,
  output logic [jeti_pkg::DMAG_W-1:0]          out_derivative_magnitude_sq,
  // configuration writes
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [jeti_pkg::Z_W-1:0]             cfg_wdata
);
  import jeti_pkg::*;

  cfg_t     cfg_r;
  logic     out_valid_r;
  result_t  out_r;

  logic     seq_idle;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // the output register frees up when empty or drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  // sequencer: holds z, dz, the partial squares and the count
  jeti_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .start      (in_valid && seq_idle),
    .start_real (in_start_real),
    .start_imag (in_start_imag),
    .idle       (seq_idle),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // the one multiplier every product of an iteration goes through
  jeti_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed_real <= '0;
      cfg_r.seed_imag <= '0;
      cfg_r.limit     <= LIMIT_RESET;
      cfg_r.mode      <= MODE_NONE;
      out_valid_r     <= 1'b0;
    end else begin
      // register writes, only meaningful while idle
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_SEED_REAL:   cfg_r.seed_real <= cfg_wdata;
          REG_SEED_IMAG:   cfg_r.seed_imag <= cfg_wdata;
          REG_ITER_LIMIT:  cfg_r.limit     <= cfg_wdata[COUNT_BITS-1:0];
          REG_SMOOTH_MODE: cfg_r.mode      <= mode_t'(cfg_wdata[1:0]);
        endcase
      end
      // result beat into the output register
      if (res_valid && res_ready) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready                    = seq_idle;
  assign out_valid                   = out_valid_r;
  assign out_iteration_count         = out_r.count;
  assign out_inside_set              = out_r.in_set;
  assign out_final_magnitude_sq      = out_r.fmag;
  assign out_previous_magnitude_sq   = out_r.pmag;
  assign out_derivative_magnitude_sq = out_r.dmag;

  // a pixel in flight blocks the input until its result is handed off
  `JETI_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input not blocked")
  // an escaped point must sit at or above the smaller bailout
  `JETI_ASSERT_NOW(a_escape_mag, out_valid && !out_inside_set, out_final_magnitude_sq >= BAIL_STD, "escape below bailout")
  // a point inside never reaches the larger bailout
  `JETI_ASSERT_NOW(a_inside_mag, out_valid && out_inside_set, out_final_magnitude_sq < BAIL_LOG, "inside above bailout")
  // no iteration means no previous magnitude
  `JETI_ASSERT_NOW(a_zero_count_prev, out_valid && (out_iteration_count == '0), out_previous_magnitude_sq == '0, "previous magnitude without iteration")

endmodule
